// ===== rtl/core/clfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfr_pkg: shared types and constants of the console line framer ring
// Payload structs, command codes, character codes and the level to
// severity map used by the framer and its escape stripper.
// ----------------------------------------------------------------------------
package clfr_pkg;

  // Default geometry of the line ring.
  localparam int LINE_LEN_DEF = 192;
  localparam int LINE_NUM_DEF = 64;

  // Configuration port: one register, facility, at byte address 0.
  localparam int CFG_ADDR_W = 3;
  localparam logic [4:0] FACILITY_RESET = 5'd1;

  // Command codes.
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_LEVEL = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Character codes seen by the escape stripper.
  localparam logic [7:0] CHAR_ESC      = 8'h1B;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CSI_FINAL_LO  = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI  = 8'h7E;

  localparam logic [2:0] DEFAULT_LEVEL = 3'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [2:0] new_level;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] severity;
    logic [7:0] priority_res;
    logic       line_last;
  } rsp_item_t;

  // Verdict of the escape stripper on one console byte.
  typedef struct packed {
    logic keep;     // byte belongs to the current line
    logic newline;  // byte ends the current line
  } strip_t;

  function automatic logic [2:0] level_to_severity(input logic [2:0] lv);
    logic [2:0] sev;
    unique case (lv)
      3'd1:    sev = 3'd3;
      3'd2:    sev = 3'd4;
      3'd3:    sev = 3'd6;
      3'd4:    sev = 3'd7;
      default: sev = 3'd6;
    endcase
    return sev;
  endfunction

endpackage

// ===== rtl/core/console_line_framer_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_framer_ring: console byte stream to syslog line ring
// Strips escape sequences, frames lines into a ring in block RAM and hands
// stored bytes back one at a time with their syslog priority.
// ----------------------------------------------------------------------------
// A console byte or a set-level command completes in the cycle it is taken,
// so a stream of those runs at one beat per clock. A read command passes
// S_IDLE, where the line store and the line header memory are read as the
// beat is accepted, then S_READ, where the result is registered once the read
// data has arrived and the output register is free. While a result waits
// in the output register the next command is still taken, but an accepted
// read then holds the command channel, for every kind of command, until the
// output register is free. A read of an empty ring gives no result. Lines
// live in one RAM of LINE_LEN*LINE_NUM bytes, slot by slot, and each stored
// line has a header entry (length and level) in a second RAM of LINE_NUM
// entries. Neither memory is cleared after reset, and there is no
// initialization pass. The ring holds at most LINE_NUM-1 lines; a line
// completed into a full ring is discarded. The facility register sits at
// byte address 0 of the APB port and resets to 1.
// ----------------------------------------------------------------------------
module console_line_framer_ring
  import clfr_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF,
  parameter int LINE_NUM = LINE_NUM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command channel.
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_item_t             cmd,
  // Response channel.
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_item_t             rsp,
  // APB configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Length counters must be able to hold LINE_LEN itself.
  localparam int LEN_W   = $clog2(LINE_LEN + 1);
  localparam int SLOT_W  = $clog2(LINE_NUM);
  localparam int DEPTH   = LINE_LEN * LINE_NUM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int META_W  = LEN_W + 3;

  localparam logic [ADDR_W-1:0] LEN_A    = ADDR_W'(LINE_LEN);
  localparam logic [LEN_W-1:0]  LEN_FULL = LEN_W'(LINE_LEN);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(LINE_NUM - 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;

  // Control state.
  logic [4:0]        facility;
  logic [LEN_W-1:0]  asm_len;
  logic [LEN_W-1:0]  asm_len_next;
  logic [2:0]        pending_level;
  logic [2:0]        pending_level_next;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] read_slot;
  logic [SLOT_W-1:0] read_slot_next;
  logic [LEN_W-1:0]  read_offset;
  logic [LEN_W-1:0]  read_offset_next;

  // Memory ports.
  logic              store_we;
  logic [ADDR_W-1:0] store_waddr;
  logic [7:0]        store_wdata;
  logic              rd_go;
  logic [ADDR_W-1:0] store_raddr;
  logic [7:0]        store_rdata;
  logic              meta_we;
  logic [SLOT_W-1:0] meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;

  // Datapath.
  logic              accept;
  logic              byte_go;
  strip_t            verdict;
  logic              ring_empty;
  logic [SLOT_W-1:0] write_slot_inc;
  logic [SLOT_W-1:0] read_slot_inc;
  logic              commit_fits;
  logic              do_commit;
  logic [SLOT_W-1:0] wr_slot;
  logic [LEN_W-1:0]  wr_off;
  logic [LEN_W-1:0]  rd_off;
  logic              finish;
  logic [LEN_W-1:0]  line_len;
  logic [2:0]        line_sev;
  logic              line_last;
  logic              cfg_write;

  assign accept  = cmd_valid && cmd_ready;
  assign byte_go = accept && (cmd.command == CMD_BYTE);

  clfr_strip u_strip (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_go),
    .data_byte  (cmd.data_byte),
    .verdict    (verdict)
  );

  clfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (rd_go),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  clfr_ram #(
    .WIDTH (META_W),
    .DEPTH (LINE_NUM)
  ) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (rd_go),
    .raddr (read_slot),
    .rdata (meta_rdata)
  );

  // Slot arithmetic, the ring need not be a power of two deep.
  assign write_slot_inc = (write_slot == SLOT_MAX) ? '0 : write_slot + 1'b1;
  assign read_slot_inc  = (read_slot == SLOT_MAX) ? '0 : read_slot + 1'b1;
  assign ring_empty     = (read_slot == write_slot);
  // A non-empty line is stored only if the ring keeps one slot free.
  assign commit_fits    = (asm_len != '0) && (write_slot_inc != read_slot);

  // Write side: console bytes and level commands finish in the accept cycle.
  always_comb begin
    do_commit          = 1'b0;
    store_we           = 1'b0;
    wr_slot            = write_slot;
    wr_off             = asm_len;
    asm_len_next       = asm_len;
    pending_level_next = pending_level;
    write_slot_next    = write_slot;

    if (byte_go && verdict.newline) begin
      do_commit = 1'b1;
    end
    if (byte_go && verdict.keep) begin
      store_we = 1'b1;
      if (asm_len == LEN_FULL) begin
        // A full line is closed first and the byte opens the next one.
        do_commit = 1'b1;
        wr_slot   = commit_fits ? write_slot_inc : write_slot;
        wr_off    = '0;
      end
    end

    if (do_commit) begin
      asm_len_next       = '0;
      pending_level_next = DEFAULT_LEVEL;
      if (commit_fits) begin
        write_slot_next = write_slot_inc;
      end
    end
    if (store_we) begin
      asm_len_next = wr_off + 1'b1;
    end
    if (accept && (cmd.command == CMD_LEVEL)) begin
      pending_level_next = cmd.new_level;
    end
  end

  assign meta_we     = do_commit && commit_fits;
  assign meta_waddr  = write_slot;
  assign meta_wdata  = {asm_len, pending_level};
  assign store_waddr = ADDR_W'(wr_slot) * LEN_A + ADDR_W'(wr_off);
  assign store_wdata = cmd.data_byte;

  // Read side: issue both memory reads on accept, finish in S_READ once the output register is free.
  assign rd_go       = accept && (cmd.command == CMD_READ) && !ring_empty;
  assign rd_off      = (read_offset >= LEN_FULL) ? '0 : read_offset;
  assign store_raddr = ADDR_W'(read_slot) * LEN_A + ADDR_W'(rd_off);

  assign finish    = (state == S_READ) && (!rsp_valid || rsp_ready);
  assign line_len  = meta_rdata[META_W-1:3];
  assign line_sev  = level_to_severity(meta_rdata[2:0]);
  assign line_last = ({1'b0, read_offset} + 1'b1) >= {1'b0, line_len};

  always_comb begin
    state_next       = state;
    read_offset_next = read_offset;
    read_slot_next   = read_slot;
    unique case (state)
      S_IDLE: begin
        if (rd_go) begin
          state_next       = S_READ;
          read_offset_next = rd_off;
        end
      end
      S_READ: begin
        if (finish) begin
          state_next = S_IDLE;
          if (line_last) begin
            read_offset_next = '0;
            read_slot_next   = read_slot_inc;
          end else begin
            read_offset_next = read_offset + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cmd_ready = (state == S_IDLE);

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[CFG_ADDR_W-1];
  assign prdata    = paddr[CFG_ADDR_W-1] ? 32'd0 : {27'd0, facility};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      facility      <= FACILITY_RESET;
      asm_len       <= '0;
      pending_level <= DEFAULT_LEVEL;
      write_slot    <= '0;
      read_slot     <= '0;
      read_offset   <= '0;
    end else begin
      state         <= state_next;
      asm_len       <= asm_len_next;
      pending_level <= pending_level_next;
      write_slot    <= write_slot_next;
      read_slot     <= read_slot_next;
      read_offset   <= read_offset_next;
      if (cfg_write) begin
        facility <= pwdata[4:0];
      end
      if (finish) begin
        rsp_valid        <= 1'b1;
        rsp.out_byte     <= store_rdata;
        rsp.severity     <= line_sev;
        rsp.priority_res <= {facility, 3'd0} + {5'd0, line_sev};
        rsp.line_last    <= line_last;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A read in flight blocks new commands.
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !cmd_ready)
    else $error("command taken while a read is in flight");

  // A read is only in flight on a non-empty ring.
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (read_slot != write_slot))
    else $error("read in flight on an empty ring");

  // A new response follows a memory read.
  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_READ))
    else $error("response without a memory read");

  // The line under assembly never exceeds the slot size.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    asm_len <= LEN_FULL)
    else $error("assembled line longer than a slot");

endmodule

// ===== rtl/core/clfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfr_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// while no read is requested.
// ----------------------------------------------------------------------------
module clfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/clfr_strip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfr_strip: console escape sequence and carriage return stripper
// Tracks ESC and ESC '[' sequences and classifies each console byte as
// part of the line, a line end, or dropped.
// ----------------------------------------------------------------------------
module clfr_strip
  import clfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  output strip_t     verdict
);

  typedef enum logic [1:0] {
    PH_NONE,
    PH_ESC,
    PH_CSI
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  always_comb begin
    phase_next      = phase;
    verdict.keep    = 1'b0;
    verdict.newline = 1'b0;
    if (byte_valid) begin
      unique case (phase)
        PH_CSI: begin
          // A control sequence ends on its final byte.
          if (data_byte >= CSI_FINAL_LO && data_byte <= CSI_FINAL_HI) begin
            phase_next = PH_NONE;
          end
        end
        PH_ESC: begin
          phase_next = (data_byte == CHAR_LBRACKET) ? PH_CSI : PH_NONE;
        end
        PH_NONE: begin
          if (data_byte == CHAR_ESC) begin
            phase_next = PH_ESC;
          end else if (data_byte == CHAR_LF) begin
            verdict.newline = 1'b1;
          end else if (data_byte != CHAR_CR) begin
            verdict.keep = 1'b1;
          end
        end
        default: begin
          phase_next = PH_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NONE;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

// ===== verif/line_ring_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_ring_checker: response predictor for the console line framer ring
// Watches the command, response and APB channels, keeps its own copy of the
// escape stripper, line ring and facility, and compares every response beat.
// ----------------------------------------------------------------------------
module line_ring_checker
  import clfr_pkg::*;
#(
  parameter logic [CFG_ADDR_W-1:0] FAC_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_ready,
  input  cmd_item_t             cmd,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  rsp_item_t             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    failures,
  output int                    outstanding
);

  localparam int LL = LINE_LEN_DEF;
  localparam int LN = LINE_NUM_DEF;

  // Console levels and the syslog severities they map to.
  localparam logic [2:0] LVL_ERROR   = 3'd1;
  localparam logic [2:0] LVL_WARNING = 3'd2;
  localparam logic [2:0] LVL_INFO    = 3'd3;
  localparam logic [2:0] LVL_DEBUG   = 3'd4;
  localparam logic [2:0] SEV_ERR     = 3'd3;
  localparam logic [2:0] SEV_WARNING = 3'd4;
  localparam logic [2:0] SEV_INFO    = 3'd6;
  localparam logic [2:0] SEV_DEBUG   = 3'd7;

  typedef enum logic [1:0] {STRIP_PLAIN, STRIP_ESC, STRIP_CSI} strip_phase_t;

  logic [7:0]   ring_text [LL*LN];
  logic [7:0]   ring_len  [LN];
  logic [2:0]   ring_lvl  [LN];
  strip_phase_t strip_phase;
  int unsigned  part_len;
  int unsigned  wr_slot;
  int unsigned  rd_slot;
  int unsigned  rd_pos;
  logic [2:0]   part_lvl;
  logic [4:0]   facility;
  rsp_item_t    due_bytes [$];
  int           err_total = 0;

  function automatic logic [2:0] severity_for(input logic [2:0] lv);
    unique case (lv)
      LVL_ERROR:   return SEV_ERR;
      LVL_WARNING: return SEV_WARNING;
      LVL_INFO:    return SEV_INFO;
      LVL_DEBUG:   return SEV_DEBUG;
      default:     return SEV_INFO;
    endcase
  endfunction

  // Ends the line being assembled. A full ring drops it; the level always
  // falls back to the default.
  function automatic void close_line();
    int unsigned nxt;
    if (part_len != 0) begin
      nxt = (wr_slot + 1) % LN;
      if (nxt != rd_slot) begin
        ring_len[wr_slot] = part_len[7:0];
        ring_lvl[wr_slot] = part_lvl;
        wr_slot = nxt;
      end
      part_len = 0;
    end
    part_lvl = DEFAULT_LEVEL;
  endfunction

  function automatic void take_console_byte(input logic [7:0] c);
    unique case (strip_phase)
      STRIP_CSI: begin
        if (c >= CSI_FINAL_LO && c <= CSI_FINAL_HI) strip_phase = STRIP_PLAIN;
      end
      STRIP_ESC: begin
        if (c == CHAR_LBRACKET) strip_phase = STRIP_CSI;
        else strip_phase = STRIP_PLAIN;
      end
      default: begin
        if (c == CHAR_ESC) begin
          strip_phase = STRIP_ESC;
        end else if (c == CHAR_LF) begin
          close_line();
        end else if (c != CHAR_CR) begin
          if (part_len >= LL) close_line();
          ring_text[wr_slot*LL + part_len] = c;
          part_len++;
        end
      end
    endcase
  endfunction

  function automatic void serve_read();
    rsp_item_t  r;
    logic [2:0] sev;
    if (rd_slot == wr_slot) return;
    if (rd_pos >= LL) rd_pos = 0;
    sev = severity_for(ring_lvl[rd_slot]);
    r.out_byte     = ring_text[rd_slot*LL + rd_pos];
    r.severity     = sev;
    r.priority_res = {facility, 3'b000} + {5'd0, sev};
    r.line_last    = (rd_pos + 1 >= ring_len[rd_slot]);
    due_bytes.push_back(r);
    if (r.line_last) begin
      rd_pos  = 0;
      rd_slot = (rd_slot + 1) % LN;
    end else begin
      rd_pos++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      strip_phase = STRIP_PLAIN;
      part_len    = 0;
      part_lvl    = DEFAULT_LEVEL;
      wr_slot     = 0;
      rd_slot     = 0;
      rd_pos      = 0;
      facility    = FACILITY_RESET;
      due_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == FAC_ADDR)
        facility = pwdata[4:0];
      if (cmd_valid && cmd_ready) begin
        unique case (cmd.command)
          CMD_BYTE:  take_console_byte(cmd.data_byte);
          CMD_LEVEL: part_lvl = cmd.new_level;
          CMD_READ:  serve_read();
          default:   ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (due_bytes.size() == 0) begin
          $error("response beat with no byte due: out_byte 0x%0h", rsp.out_byte);
          err_total++;
        end else begin
          want = due_bytes.pop_front();
          check_field("out_byte", want.out_byte, rsp.out_byte);
          check_field("severity", {5'd0, want.severity}, {5'd0, rsp.severity});
          check_field("priority_res", want.priority_res, rsp.priority_res);
          check_field("line_last", {7'd0, want.line_last}, {7'd0, rsp.line_last});
        end
      end
    end
    outstanding <= due_bytes.size();
    failures    <= err_total;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the console line framer ring
// Drives console bytes, level tags and reads with bursty timing, stalls the
// response side, steps the facility register through several settings and
// leaves all prediction and comparison to line_ring_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import clfr_pkg::*;

  // Command code that the block has no use for; it must be ignored.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Register map: facility is register 0; the next word up holds nothing.
  localparam logic [CFG_ADDR_W-1:0] FACILITY_ADDR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR    = 3'd4;

  // Console levels used by the directed beats.
  localparam logic [2:0] LVL_NONE    = 3'd0;
  localparam logic [2:0] LVL_WARNING = 3'd2;
  localparam logic [2:0] LVL_HIGHEST = 3'd7;

  // A read shows up on the response side once its memory read and the output
  // register are through; the margin also covers a read of an empty ring.
  localparam int READ_LATENCY = 4;
  // The longest quiet stretch of a correct run is a settle pause plus two
  // register writes, or a run of sink stalls at one-in-eight; this limit is
  // far above either of those.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_GOAL      = 1550;
  localparam int PHASES         = 4;

  typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SLOW} sink_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_ready;
  cmd_item_t             cmd;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_item_t             rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int         chk_failures;
  int         chk_outstanding;
  int         beats_sent  = 0;
  int         burst_left  = 0;
  int         idle_cycles = 0;
  int         sink_left   = 0;
  sink_mode_t sink_mode   = SINK_OPEN;

  console_line_framer_ring uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  line_ring_checker #(
    .FAC_ADDR (FACILITY_ADDR)
  ) ring_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (chk_failures),
    .outstanding (chk_outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The response sink switches between wide open, coin-flip and mostly
  // stalled, holding each pattern for a random stretch of cycles.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(20, 150);
    end
    sink_left--;
    unique case (sink_mode)
      SINK_OPEN: rsp_ready <= 1'b1;
      SINK_HALF: rsp_ready <= ($urandom_range(0, 1) == 1);
      default:   rsp_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Beat builders. Fields the command does not use get random values, so
  // the block is shown that it must not look at them.
  function automatic cmd_item_t byte_beat(input logic [7:0] b);
    cmd_item_t it;
    it.command   = CMD_BYTE;
    it.data_byte = b;
    it.new_level = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic cmd_item_t level_beat(input logic [2:0] lv);
    cmd_item_t it;
    it.command   = CMD_LEVEL;
    it.data_byte = 8'($urandom_range(0, 255));
    it.new_level = lv;
    return it;
  endfunction

  function automatic cmd_item_t read_beat();
    cmd_item_t it;
    it.command   = CMD_READ;
    it.data_byte = 8'($urandom_range(0, 255));
    it.new_level = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic cmd_item_t noise_beat();
    cmd_item_t it;
    it.command   = 2'($urandom_range(0, 3));
    it.data_byte = 8'($urandom_range(0, 255));
    it.new_level = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // Sends one command beat, starting and ending at a falling edge. Beats go
  // out in bursts; between most bursts valid drops for a random gap. Some
  // bursts are long, which gives stretches with no idling at all.
  task automatic put_beat(input cmd_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    cmd       <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
    if (it.command != CMD_SPARE) beats_sent++;
  endtask

  // Drops valid and waits until every predicted byte has come back, plus a
  // margin for a read that finds the ring empty.
  task automatic settle();
    cmd_valid <= 1'b0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (READ_LATENCY) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands at the access edge.
  // The trailing cycle keeps back-to-back writes from colliding on psel.
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // One console line with random content. Escape sequences, stray CRs and
  // level tags are sprinkled in; the occasional long line runs past
  // LINE_LEN and forces a split. Most lines end with a newline, some run on
  // into the next one, and a zero length makes an empty line.
  task automatic send_line(input int len);
    int i;
    int pick;
    int n;
    if ($urandom_range(0, 3) == 0) put_beat(level_beat(3'($urandom_range(0, 7))));
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 29);
      unique case (pick)
        0: begin
          put_beat(byte_beat(CHAR_ESC));
          put_beat(byte_beat(8'($urandom_range(0, 255))));
        end
        1: begin
          put_beat(byte_beat(CHAR_ESC));
          put_beat(byte_beat(CHAR_LBRACKET));
          n = $urandom_range(0, 3);
          repeat (n) put_beat(byte_beat(8'($urandom_range(8'h30, 8'h3F))));
          put_beat(byte_beat(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI))));
        end
        2: put_beat(byte_beat(CHAR_CR));
        3: put_beat(level_beat(3'($urandom_range(0, 7))));
        default: put_beat(byte_beat(8'($urandom_range(32, 255))));
      endcase
    end
    if ($urandom_range(0, 9) != 0) put_beat(byte_beat(CHAR_LF));
  endtask

  // Short lines with no reads in between, enough to fill the ring and have
  // the last few lines dropped.
  task automatic fill_ring();
    repeat (LINE_NUM_DEF + 3) begin
      put_beat(byte_beat(8'($urandom_range(32, 126))));
      put_beat(byte_beat(CHAR_LF));
    end
  endtask

  task automatic random_step();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_line(($urandom_range(0, 24) == 0) ? $urandom_range(185, 200)
                                             : $urandom_range(0, 12));
    end else if (pick < 80) begin
      n = $urandom_range(1, 40);
      repeat (n) put_beat(read_beat());
    end else if (pick < 97) begin
      n = $urandom_range(1, 6);
      repeat (n) put_beat(noise_beat());
    end else begin
      fill_ring();
    end
  endtask

  initial begin
    logic [31:0] fac_setting [PHASES];
    int          phase;
    int          phase_goal;

    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    rsp_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // Facility settings for the random phases: both extremes of the legal
    // range, an all-ones word that the register must trim to five bits,
    // and a random legal value.
    fac_setting[0] = 32'd0;
    fac_setting[1] = 32'd23;
    fac_setting[2] = 32'hFFFF_FFFF;
    fac_setting[3] = $urandom_range(0, 23);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, run with the facility still at its reset value. The
    // first line carries the smallest and largest byte around a CSI
    // sequence that ends on the lowest final byte, and a CR to be dropped.
    put_beat(level_beat(LVL_WARNING));
    put_beat(byte_beat(8'h00));
    put_beat(byte_beat(CHAR_ESC));
    put_beat(byte_beat(CHAR_LBRACKET));
    put_beat(byte_beat(8'h3F));
    put_beat(byte_beat(CSI_FINAL_LO));
    put_beat(byte_beat(8'hFF));
    put_beat(byte_beat(CHAR_CR));
    put_beat(byte_beat(CHAR_LF));
    // An empty line must not be stored.
    put_beat(byte_beat(CHAR_LF));
    // Out-of-range level; a two-byte escape; the highest final byte seen
    // outside an escape is an ordinary character. The unused command code
    // must leave everything alone.
    put_beat(level_beat(LVL_HIGHEST));
    put_beat(byte_beat(CHAR_ESC));
    put_beat(byte_beat(8'h41));
    put_beat(byte_beat(CSI_FINAL_HI));
    put_beat(noise_beat() & ~13'h0 | {CMD_SPARE, 11'h0});
    put_beat(byte_beat(CHAR_LF));
    // Three stored bytes, then a read of the now empty ring.
    repeat (4) put_beat(read_beat());
    // Level zero maps to the default severity.
    put_beat(level_beat(LVL_NONE));
    put_beat(byte_beat(8'h80));
    put_beat(byte_beat(CHAR_LF));
    put_beat(read_beat());

    // Random phases, each under its own facility setting. The register is
    // only touched once the block has gone quiet. A write to the empty
    // address next to it must change nothing.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      apb_write(FACILITY_ADDR, fac_setting[phase]);
      if (phase == 1) apb_write(SPARE_ADDR, $urandom);
      phase_goal = beats_sent + ITEM_GOAL / PHASES;
      while (beats_sent < phase_goal) random_step();
    end

    settle();
    if (chk_failures == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/clfr_pkg.sv
rtl/core/clfr_ram.sv
rtl/core/clfr_strip.sv
rtl/core/console_line_framer_ring.sv
verif/line_ring_checker.sv
verif/tb_top.sv
